// File: hw/rtl/pd_pkg.sv
// ----------------------------------------------------------------------------
// pd_pkg
// Shared types and constants for the positional deque: operation and status
// codes, the per-item control bundle and parameter defaults.
// ----------------------------------------------------------------------------
package pd_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned POSITION_W = 5;
  localparam int unsigned DATA_IN_W  = 32;
  localparam int unsigned DATA_OUT_W = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT_AT  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_DELETE_AT  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Decoded action for one item
  typedef struct packed {
    logic    ins;     // open a slot at idx and write the new word
    logic    rem;     // close the slot at idx
    status_e status;
  } ctrl_t;

endpackage

// File: hw/rtl/pd_cell.sv
// ----------------------------------------------------------------------------
// pd_cell
// One storage cell of the chain. Shifts toward the back on insert, toward the
// front on remove, loads the new word when it is the insert slot.
// ----------------------------------------------------------------------------
module pd_cell #(
  parameter int unsigned CELL_IDX   = 0,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned DATA_WIDTH = pd_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  pd_pkg::ctrl_t         ctrl_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [DATA_WIDTH-1:0] new_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] word_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [DATA_WIDTH-1:0] word_q;
  logic [DATA_WIDTH-1:0] word_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.ins) begin
      if (MyIdx > idx_i) begin
        word_d = left_i;
      end else if (MyIdx == idx_i) begin
        word_d = new_i;
      end
    end else if (ctrl_i.rem) begin
      if (MyIdx >= idx_i) begin
        word_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// File: hw/rtl/pd_ctrl.sv
// ----------------------------------------------------------------------------
// pd_ctrl
// Decodes one item against the current count: chooses the slot, checks the
// full / empty / position rules and produces the next count.
// ----------------------------------------------------------------------------
module pd_ctrl #(
  parameter int unsigned DEPTH = pd_pkg::DEPTH_DEF
) (
  input  logic [pd_pkg::OPCODE_W-1:0]   opcode_i,
  input  logic [pd_pkg::POSITION_W-1:0] position_i,
  input  logic [$clog2(DEPTH+1)-1:0]    occ_i,
  output pd_pkg::ctrl_t                 ctrl_o,
  output logic [$clog2(DEPTH)-1:0]      idx_o,
  output logic [$clog2(DEPTH+1)-1:0]    occ_next_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CMP_W =
    ((CNT_W > pd_pkg::POSITION_W) ? CNT_W : pd_pkg::POSITION_W) + 1;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] occ_x;
  logic             full;
  logic             empty;
  logic             ins_bad;
  logic             del_bad;

  assign pos_x   = CMP_W'(position_i);
  assign occ_x   = CMP_W'(occ_i);
  assign full    = (occ_i == CNT_W'(DEPTH));
  assign empty   = (occ_i == '0);
  assign ins_bad = (pos_x == '0) || (pos_x > occ_x + CMP_W'(1));
  assign del_bad = (pos_x == '0) || (pos_x > occ_x);

  always_comb begin
    ctrl_o.ins    = 1'b0;
    ctrl_o.rem    = 1'b0;
    ctrl_o.status = pd_pkg::ST_OK;
    idx_o         = '0;
    unique case (opcode_i) inside
      pd_pkg::OP_PUSH_FRONT, pd_pkg::OP_PUSH_BACK, pd_pkg::OP_INSERT_AT: begin
        if (full) begin
          ctrl_o.status = pd_pkg::ST_FULL;
        end else if (opcode_i == pd_pkg::OP_PUSH_FRONT) begin
          ctrl_o.ins = 1'b1;
        end else if (opcode_i == pd_pkg::OP_PUSH_BACK) begin
          ctrl_o.ins = 1'b1;
          idx_o      = IDX_W'(occ_i);
        end else if (ins_bad) begin
          ctrl_o.status = pd_pkg::ST_BADPOS;
        end else begin
          ctrl_o.ins = 1'b1;
          idx_o      = IDX_W'(pos_x - CMP_W'(1));
        end
      end
      pd_pkg::OP_POP_FRONT, pd_pkg::OP_POP_BACK, pd_pkg::OP_DELETE_AT: begin
        if (empty) begin
          ctrl_o.status = pd_pkg::ST_EMPTY;
        end else if (opcode_i == pd_pkg::OP_POP_FRONT) begin
          ctrl_o.rem = 1'b1;
        end else if (opcode_i == pd_pkg::OP_POP_BACK) begin
          ctrl_o.rem = 1'b1;
          idx_o      = IDX_W'(occ_i - CNT_W'(1));
        end else if (del_bad) begin
          ctrl_o.status = pd_pkg::ST_BADPOS;
        end else begin
          ctrl_o.rem = 1'b1;
          idx_o      = IDX_W'(pos_x - CMP_W'(1));
        end
      end
      default: begin
        ctrl_o.status = pd_pkg::ST_BADPOS;
      end
    endcase
  end

  always_comb begin
    occ_next_o = occ_i;
    if (ctrl_o.ins) begin
      occ_next_o = occ_i + CNT_W'(1);
    end else if (ctrl_o.rem) begin
      occ_next_o = occ_i - CNT_W'(1);
    end
  end

endmodule

// File: hw/rtl/positional_deque_top.sv
// ----------------------------------------------------------------------------
// positional_deque_top
// Ordered list of up to DEPTH words with push/pop at both ends and indexed
// insert/delete, built as a chain of shifting storage cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one operation per item (opcode, 1-based position,
//   data word). Master stream returns exactly one result item per operation:
//   the word stored or removed (zero on any failure), a status code and the
//   element count after the operation.
//   Each accepted item is executed in the cycle it is accepted: the cell chain
//   shifts the entries from the slot onward by one place in that same edge, so
//   the result appears on the master side in the next cycle. One item per cycle
//   is sustained while the receiver takes results; the limit is the shift of the
//   cell chain plus the count update that the next item depends on.
//   A result held in the output register while the receiver stalls keeps the
//   slave side ready only if that result is taken in the same cycle, so a
//   stalled receiver blocks new items after one result is pending.
//   Reset clears the count and the output valid; cell contents are undefined
//   until written and are never read beyond the count.
// ----------------------------------------------------------------------------
module positional_deque_top #(
  parameter int unsigned DEPTH      = pd_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = pd_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] opcode, [7:3] position, [39:8] data_in
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] data_out, [33:32] status, [38:34] count, [39] zero
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [pd_pkg::OPCODE_W-1:0]   opcode;
  logic [pd_pkg::POSITION_W-1:0] position;
  logic [pd_pkg::DATA_IN_W-1:0]  data_in;
  logic [DATA_WIDTH-1:0]         new_word;

  logic                          accept;
  pd_pkg::ctrl_t                 ctrl;
  pd_pkg::ctrl_t                 cell_ctrl;
  logic [IDX_W-1:0]              idx;
  logic [CNT_W-1:0]              occ_q;
  logic [CNT_W-1:0]              occ_next;

  logic [DATA_WIDTH-1:0]         cell_word [DEPTH];
  logic [DATA_WIDTH-1:0]         res_word;

  logic                          out_valid_q;
  logic [pd_pkg::DATA_OUT_W-1:0] data_out_q;
  logic [pd_pkg::STATUS_W-1:0]   status_q;
  logic [pd_pkg::COUNT_W-1:0]    count_q;

  assign opcode   = s_axis_tdata[2:0];
  assign position = s_axis_tdata[7:3];
  assign data_in  = s_axis_tdata[39:8];
  assign new_word = DATA_WIDTH'(data_in);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  pd_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .opcode_i   (opcode),
    .position_i (position),
    .occ_i      (occ_q),
    .ctrl_o     (ctrl),
    .idx_o      (idx),
    .occ_next_o (occ_next)
  );

  always_comb begin
    cell_ctrl     = ctrl;
    cell_ctrl.ins = ctrl.ins && accept;
    cell_ctrl.rem = ctrl.rem && accept;
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (k == 0) begin : g_first
      assign left_w = new_word;
    end else begin : g_left
      assign left_w = cell_word[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_w = cell_word[k];
    end else begin : g_right
      assign right_w = cell_word[k+1];
    end

    pd_cell #(
      .CELL_IDX   (k),
      .IDX_W      (IDX_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .idx_i   (idx),
      .new_i   (new_word),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[k])
    );
  end

  // Removed word comes from the chain before it shifts
  always_comb begin
    res_word = '0;
    if (ctrl.ins) begin
      res_word = new_word;
    end else if (ctrl.rem) begin
      res_word = cell_word[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q       <= occ_next;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_out_q <= pd_pkg::DATA_OUT_W'(res_word);
      status_q   <= ctrl.status;
      count_q    <= pd_pkg::COUNT_W'(occ_next);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, count_q, status_q, data_out_q};

endmodule

// File: hw/rtl/pd_checker.sv
// ----------------------------------------------------------------------------
// pd_checker
// Port-level checks for the positional deque, bound to the top level.
// ----------------------------------------------------------------------------
module pd_checker #(
  parameter int unsigned DEPTH = pd_pkg::DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Every accepted item yields a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result after accepted item");

  // Failed operations return a zero word
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[33:32] != pd_pkg::ST_OK)
      |-> (m_axis_tdata[31:0] == '0))
    else $error("nonzero word with failing status");

  // Empty only reported with zero count, full only with DEPTH held
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[33:32] == pd_pkg::ST_EMPTY)
      |-> (m_axis_tdata[38:34] == '0))
    else $error("empty status with nonzero count");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[33:32] == pd_pkg::ST_FULL)
      |-> (m_axis_tdata[38:34] == pd_pkg::COUNT_W'(DEPTH)))
    else $error("full status with count below depth");

endmodule

bind positional_deque_top pd_checker #(.DEPTH(DEPTH)) u_pd_checker (.*);

// File: bench/positional_deque_top_tb.sv
// ----------------------------------------------------------------------------
// positional_deque_top_tb
// Self-checking bench for the positional deque. A queue of operations is
// built up front (directed corner cases, then fill/drain/mixed random phases)
// and played into the slave stream. Every accepted item is run through a
// shadow list here, and each result on the master stream is compared field
// by field with the oldest predicted result. Both sides idle at random, and
// the receiver holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module positional_deque_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = pd_pkg::DEPTH_DEF;
  localparam int unsigned OPCODE_W   = pd_pkg::OPCODE_W;
  localparam int unsigned POSITION_W = pd_pkg::POSITION_W;
  localparam int unsigned DATA_IN_W  = pd_pkg::DATA_IN_W;
  localparam int unsigned DATA_OUT_W = pd_pkg::DATA_OUT_W;
  localparam int unsigned COUNT_W    = pd_pkg::COUNT_W;
  localparam int unsigned NUM_RANDOM = 1100;
  localparam int unsigned IDLE_PCT   = 18;

  // opcodes outside the defined set
  localparam logic [OPCODE_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RSVD_7 = 3'd7;

  // cycle windows (counted after reset) for the no-idle stretch and hold-off
  localparam int unsigned QUIET_FROM = 300;
  localparam int unsigned QUIET_TO   = 700;
  localparam int unsigned HOLD_FROM  = 1000;
  localparam int unsigned HOLD_TO    = 1160;

  typedef struct {
    logic [OPCODE_W-1:0]   op;
    logic [POSITION_W-1:0] pos;
    logic [DATA_IN_W-1:0]  word;
  } deque_op_t;

  typedef struct {
    logic [DATA_OUT_W-1:0] word;
    pd_pkg::status_e       status;
    logic [COUNT_W-1:0]    count;
  } deque_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  deque_op_t             pending_ops[$];
  deque_result_t         expected_results[$];
  logic [DATA_IN_W-1:0]  shadow_list[$];

  logic        in_fire;
  int unsigned cycle_n;
  logic        quiet;
  logic        hold_off;
  int unsigned planned_count;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned status_seen[4];
  int unsigned peak_count;

  positional_deque_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Shadow list: applies one operation, returns the result it should give.
  function automatic deque_result_t apply_op(input deque_op_t item);
    deque_result_t r;
    int unsigned   n;
    n        = shadow_list.size();
    r.word   = '0;
    r.status = pd_pkg::ST_OK;
    case (item.op) inside
      pd_pkg::OP_PUSH_FRONT, pd_pkg::OP_PUSH_BACK, pd_pkg::OP_INSERT_AT: begin
        if (n >= DEPTH) begin
          r.status = pd_pkg::ST_FULL;
        end else if (item.op == pd_pkg::OP_PUSH_FRONT) begin
          shadow_list.push_front(item.word);
          r.word = item.word;
        end else if (item.op == pd_pkg::OP_PUSH_BACK) begin
          shadow_list.push_back(item.word);
          r.word = item.word;
        end else if (item.pos < 1 || item.pos > n + 1) begin
          r.status = pd_pkg::ST_BADPOS;
        end else begin
          shadow_list.insert(item.pos - 1, item.word);
          r.word = item.word;
        end
      end
      pd_pkg::OP_POP_FRONT, pd_pkg::OP_POP_BACK, pd_pkg::OP_DELETE_AT: begin
        if (n == 0) begin
          r.status = pd_pkg::ST_EMPTY;
        end else if (item.op == pd_pkg::OP_POP_FRONT) begin
          r.word = shadow_list.pop_front();
        end else if (item.op == pd_pkg::OP_POP_BACK) begin
          r.word = shadow_list.pop_back();
        end else if (item.pos < 1 || item.pos > n) begin
          r.status = pd_pkg::ST_BADPOS;
        end else begin
          r.word = shadow_list[item.pos - 1];
          shadow_list.delete(item.pos - 1);
        end
      end
      default: r.status = pd_pkg::ST_BADPOS;
    endcase
    r.count = COUNT_W'(shadow_list.size());
    return r;
  endfunction

  // Queues an item and tracks the count it leaves, to steer positions.
  task automatic add_item(input logic [OPCODE_W-1:0] op, input int unsigned pos,
                          input logic [DATA_IN_W-1:0] word);
    deque_op_t item;
    item.op   = op;
    item.pos  = POSITION_W'(pos);
    item.word = word;
    pending_ops.push_back(item);
    case (op) inside
      pd_pkg::OP_PUSH_FRONT, pd_pkg::OP_PUSH_BACK:
        if (planned_count < DEPTH) planned_count++;
      pd_pkg::OP_INSERT_AT:
        if (planned_count < DEPTH && pos >= 1 && pos <= planned_count + 1) planned_count++;
      pd_pkg::OP_POP_FRONT, pd_pkg::OP_POP_BACK:
        if (planned_count > 0) planned_count--;
      pd_pkg::OP_DELETE_AT:
        if (planned_count > 0 && pos >= 1 && pos <= planned_count) planned_count--;
      default: ;
    endcase
  endtask

  function automatic logic [DATA_IN_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // Stimulus: directed corners, then fill / drain / mixed phases.
  initial begin
    int unsigned   phase;
    int unsigned   roll;
    int unsigned   push_pct;
    int unsigned   kind;
    logic [OPCODE_W-1:0] op;
    int unsigned   pos;
    planned_count = 0;

    add_item(pd_pkg::OP_POP_FRONT, 0, '1);
    add_item(pd_pkg::OP_POP_BACK, 31, '1);
    add_item(pd_pkg::OP_DELETE_AT, 1, '0);
    add_item(pd_pkg::OP_INSERT_AT, 0, 32'h1234_5678);
    add_item(pd_pkg::OP_INSERT_AT, 2, 32'h8765_4321);
    add_item(pd_pkg::OP_INSERT_AT, 1, 32'hFFFF_FFFF);
    add_item(pd_pkg::OP_PUSH_FRONT, 0, 32'h0000_0000);
    add_item(pd_pkg::OP_PUSH_BACK, 31, 32'h8000_0001);
    add_item(pd_pkg::OP_INSERT_AT, 4, 32'h5A5A_A5A5);   // at count+1
    add_item(pd_pkg::OP_DELETE_AT, 5, '0);              // one past the back
    add_item(pd_pkg::OP_DELETE_AT, 0, '0);
    add_item(pd_pkg::OP_DELETE_AT, 31, '0);
    add_item(OP_RSVD_6, 31, '1);
    add_item(OP_RSVD_7, 16, '1);
    add_item(pd_pkg::OP_DELETE_AT, 2, '0);
    add_item(pd_pkg::OP_POP_BACK, 0, '0);
    add_item(pd_pkg::OP_POP_FRONT, 0, '0);
    add_item(pd_pkg::OP_POP_FRONT, 0, '0);
    add_item(pd_pkg::OP_POP_BACK, 0, '0);

    for (int unsigned i = 0; i < NUM_RANDOM; i++) begin
      phase = (i / 48) % 3;
      case (phase)
        0:       push_pct = 75;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // noise: any opcode, any position
        add_item(OPCODE_W'($urandom_range(0, 7)), $urandom_range(0, 31), pick_word());
      end else begin
        kind = $urandom_range(0, 2);
        if ($urandom_range(0, 99) < push_pct) begin
          case (kind)
            0:       op = pd_pkg::OP_PUSH_FRONT;
            1:       op = pd_pkg::OP_PUSH_BACK;
            default: op = pd_pkg::OP_INSERT_AT;
          endcase
          pos = $urandom_range(1, planned_count + 1);
        end else begin
          case (kind)
            0:       op = pd_pkg::OP_POP_FRONT;
            1:       op = pd_pkg::OP_POP_BACK;
            default: op = pd_pkg::OP_DELETE_AT;
          endcase
          pos = (planned_count == 0) ? 1 : $urandom_range(1, planned_count);
        end
        add_item(op, pos, pick_word());
      end
    end
  end

  // Cycle counter and the windows derived from it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_n <= 0;
    end else begin
      cycle_n <= cycle_n + 1;
    end
  end

  assign quiet    = (cycle_n >= QUIET_FROM) && (cycle_n < QUIET_TO);
  assign hold_off = (cycle_n >= HOLD_FROM) && (cycle_n < HOLD_TO);

  // Sender: next item once the current one has been taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (pending_ops.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pending_ops[0].word, pending_ops[0].pos, pending_ops[0].op};
          void'(pending_ops.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Monitor: check results, then predict for the item taken at this edge
  always @(posedge clk_i) begin
    deque_result_t want;
    deque_result_t got;
    deque_op_t     item;
    in_fire <= s_axis_tvalid && s_axis_tready && rst_ni;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.word   = m_axis_tdata[31:0];
      got.status = pd_pkg::status_e'(m_axis_tdata[33:32]);
      got.count  = m_axis_tdata[38:34];
      checked++;
      status_seen[got.status]++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result word=%h status=%0d count=%0d",
                   got.word, got.status, got.count);
      end else begin
        want = expected_results.pop_front();
        if (got.word !== want.word || got.status !== want.status ||
            got.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: result %0d: expected %h/%0d/%0d, got %h/%0d/%0d",
                     checked, want.word, want.status, want.count,
                     got.word, got.status, got.count);
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      item.op   = s_axis_tdata[2:0];
      item.pos  = s_axis_tdata[7:3];
      item.word = s_axis_tdata[39:8];
      want      = apply_op(item);
      expected_results.push_back(want);
      if (want.count > peak_count) peak_count = want.count;
    end
  end

  initial begin
    mismatches  = 0;
    checked     = 0;
    peak_count  = 0;
    in_fire     = 1'b0;
    status_seen = '{default: 0};
    @(posedge rst_ni);
    do @(posedge clk_i); while (pending_ops.size() > 0 || s_axis_tvalid);
    do @(posedge clk_i); while (expected_results.size() > 0);
    repeat (5) @(posedge clk_i);
    $display("tb: %0d results checked: %0d ok, %0d empty, %0d full, %0d bad position",
             checked, status_seen[pd_pkg::ST_OK], status_seen[pd_pkg::ST_EMPTY],
             status_seen[pd_pkg::ST_FULL], status_seen[pd_pkg::ST_BADPOS]);
    $display("tb: list filled up to %0d of %0d entries, %0d mismatches",
             peak_count, DEPTH, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
